// ----- sv/gtp_pkg.sv -----
// Shared types, codes and reset values for the gamepad-to-pointer event unit.
`timescale 1ns / 1ps
`default_nettype none
package gtp_pkg;

   localparam int TIME_BITS_DEF  = 48;
   localparam int COORD_BITS_DEF = 12;

   localparam int MOVE_PERIOD_US = 16667;
   localparam int NUM_ACTIONS    = 6;
   localparam int FIRST_CHORD    = 4;   // start and select follow the four face buttons
   localparam int BOUND_BITS     = 12;
   localparam int CSR_ADDR_BITS  = 5;
   localparam int CSR_DATA_BITS  = 32;
   localparam int REG_IDX_BITS   = 3;

   typedef enum logic [3:0] {
      EV_NONE  = 4'd0,
      EV_LDOWN = 4'd1,
      EV_LUP   = 4'd2,
      EV_RDOWN = 4'd3,
      EV_RUP   = 4'd4,
      EV_KDOWN = 4'd5,
      EV_KUP   = 4'd6,
      EV_VKBD  = 4'd7,
      EV_MOVE  = 4'd8
   } event_kind_type;

   localparam logic [3:0] ACT_NONE  = 4'd0;
   localparam logic [3:0] ACT_LEFT  = 4'd1;
   localparam logic [3:0] ACT_RIGHT = 4'd2;
   localparam logic [3:0] ACT_ESC   = 4'd3;
   localparam logic [3:0] ACT_SPACE = 4'd4;
   localparam logic [3:0] ACT_F5    = 4'd5;
   localparam logic [3:0] ACT_F7    = 4'd6;
   localparam logic [3:0] ACT_ENTER = 4'd7;
   localparam logic [3:0] ACT_VKBD  = 4'd8;

   localparam logic [2:0] KEY_ESC    = 3'd0;
   localparam logic [2:0] KEY_SPACE  = 3'd1;
   localparam logic [2:0] KEY_F5     = 3'd2;
   localparam logic [2:0] KEY_F7     = 3'd3;
   localparam logic [2:0] KEY_RETURN = 3'd4;

   localparam logic [REG_IDX_BITS-1:0] REG_ACTION_MAP    = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_SLOW_STEP     = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_FAST_STEP     = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_ACCEL_TIME    = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_GAME_MAX_X    = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_GAME_MAX_Y    = 3'd5;
   localparam logic [REG_IDX_BITS-1:0] REG_OVERLAY_MAX_X = 3'd6;
   localparam logic [REG_IDX_BITS-1:0] REG_OVERLAY_MAX_Y = 3'd7;

   localparam logic [23:0] RST_ACTION_MAP    = 24'h876521;
   localparam logic [7:0]  RST_SLOW_STEP     = 8'd1;
   localparam logic [7:0]  RST_FAST_STEP     = 8'd4;
   localparam logic [31:0] RST_ACCEL_TIME    = 32'd500000;
   localparam logic [11:0] RST_GAME_MAX_X    = 12'd319;
   localparam logic [11:0] RST_GAME_MAX_Y    = 12'd199;
   localparam logic [11:0] RST_OVERLAY_MAX_X = 12'd319;
   localparam logic [11:0] RST_OVERLAY_MAX_Y = 12'd239;

   typedef struct packed {
      logic [23:0]           action_map;
      logic [7:0]            slow_step;
      logic [7:0]            fast_step;
      logic [31:0]           accel_time_us;
      logic [BOUND_BITS-1:0] game_max_x;
      logic [BOUND_BITS-1:0] game_max_y;
      logic [BOUND_BITS-1:0] overlay_max_x;
      logic [BOUND_BITS-1:0] overlay_max_y;
   } cfg_type;

   typedef struct packed {
      logic           hit;
      event_kind_type kind;
      logic [2:0]     key;
      logic           with_pos;
   } button_event_type;

   function automatic logic [2:0] key_of_action(input logic [3:0] code);
      logic [2:0] key;
      unique case (code)
         ACT_ESC:   key = KEY_ESC;
         ACT_SPACE: key = KEY_SPACE;
         ACT_F5:    key = KEY_F5;
         ACT_F7:    key = KEY_F7;
         default:   key = KEY_RETURN;   // enter and undefined codes
      endcase
      return key;
   endfunction

endpackage
`default_nettype wire

// ----- sv/gtp_csr.sv -----
// Configuration register file with an APB-style write and read port.
`timescale 1ns / 1ps
`default_nettype none
module gtp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gtp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [gtp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [gtp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready,
   output gtp_pkg::cfg_type                         cfg
);
   import gtp_pkg::*;

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;

   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ACTION_MAP:    cfg_in.action_map    = pwdata[23:0];
            REG_SLOW_STEP:     cfg_in.slow_step     = pwdata[7:0];
            REG_FAST_STEP:     cfg_in.fast_step     = pwdata[7:0];
            REG_ACCEL_TIME:    cfg_in.accel_time_us = pwdata[31:0];
            REG_GAME_MAX_X:    cfg_in.game_max_x    = pwdata[BOUND_BITS-1:0];
            REG_GAME_MAX_Y:    cfg_in.game_max_y    = pwdata[BOUND_BITS-1:0];
            REG_OVERLAY_MAX_X: cfg_in.overlay_max_x = pwdata[BOUND_BITS-1:0];
            REG_OVERLAY_MAX_Y: cfg_in.overlay_max_y = pwdata[BOUND_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ACTION_MAP:    prdata = CSR_DATA_BITS'(cfg_ff.action_map);
         REG_SLOW_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.slow_step);
         REG_FAST_STEP:     prdata = CSR_DATA_BITS'(cfg_ff.fast_step);
         REG_ACCEL_TIME:    prdata = CSR_DATA_BITS'(cfg_ff.accel_time_us);
         REG_GAME_MAX_X:    prdata = CSR_DATA_BITS'(cfg_ff.game_max_x);
         REG_GAME_MAX_Y:    prdata = CSR_DATA_BITS'(cfg_ff.game_max_y);
         REG_OVERLAY_MAX_X: prdata = CSR_DATA_BITS'(cfg_ff.overlay_max_x);
         REG_OVERLAY_MAX_Y: prdata = CSR_DATA_BITS'(cfg_ff.overlay_max_y);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.action_map    <= RST_ACTION_MAP;
         cfg_ff.slow_step     <= RST_SLOW_STEP;
         cfg_ff.fast_step     <= RST_FAST_STEP;
         cfg_ff.accel_time_us <= RST_ACCEL_TIME;
         cfg_ff.game_max_x    <= RST_GAME_MAX_X;
         cfg_ff.game_max_y    <= RST_GAME_MAX_Y;
         cfg_ff.overlay_max_x <= RST_OVERLAY_MAX_X;
         cfg_ff.overlay_max_y <= RST_OVERLAY_MAX_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// ----- sv/gtp_buttons.sv -----
// Priority scan of the six action buttons against their stored states.
`timescale 1ns / 1ps
`default_nettype none
module gtp_buttons (
   input  wire logic [gtp_pkg::NUM_ACTIONS-1:0]   acts,
   input  wire logic [gtp_pkg::NUM_ACTIONS-1:0]   seen,
   input  wire logic [4*gtp_pkg::NUM_ACTIONS-1:0] action_map,
   output gtp_pkg::button_event_type              ev,
   output logic      [gtp_pkg::NUM_ACTIONS-1:0]   seen_next
);
   import gtp_pkg::*;

   logic chord;

   assign chord = acts[NUM_ACTIONS-1] & acts[NUM_ACTIONS-2];

   always_comb begin
      logic       found;
      logic       dn;
      logic [3:0] code;
      found     = 1'b0;
      seen_next = seen;
      ev        = '{hit: 1'b0, kind: EV_NONE, key: KEY_ESC, with_pos: 1'b0};
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         dn   = acts[i];
         code = action_map[4*i +: 4];
         // buttons after the first event stay as they were
         if (!found && (dn != seen[i])) begin
            seen_next[i] = dn;
            if (!(i >= FIRST_CHORD && chord)) begin
               case (code)
                  ACT_NONE: ;
                  ACT_LEFT: begin
                     found       = 1'b1;
                     ev.kind     = dn ? EV_LDOWN : EV_LUP;
                     ev.with_pos = 1'b1;
                  end
                  ACT_RIGHT: begin
                     found       = 1'b1;
                     ev.kind     = dn ? EV_RDOWN : EV_RUP;
                     ev.with_pos = 1'b1;
                  end
                  ACT_VKBD: begin
                     if (dn) begin
                        found   = 1'b1;
                        ev.kind = EV_VKBD;
                     end
                  end
                  default: begin
                     found   = 1'b1;
                     ev.kind = dn ? EV_KDOWN : EV_KUP;
                     ev.key  = key_of_action(code);
                  end
               endcase
            end
         end
      end
      ev.hit = found;
   end

endmodule
`default_nettype wire

// ----- sv/gtp_pointer.sv -----
// Move timing, acceleration and clamped pointer step for the direction pad.
`timescale 1ns / 1ps
`default_nettype none
module gtp_pointer #(
   parameter int TIME_BITS  = gtp_pkg::TIME_BITS_DEF,
   parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF
) (
   input  wire logic [TIME_BITS-1:0]  now,
   input  wire logic [3:0]            dir,
   input  wire logic                  ovl,
   input  wire gtp_pkg::cfg_type      cfg,
   input  wire logic [TIME_BITS-1:0]  last_move,
   input  wire logic [TIME_BITS-1:0]  hold_start,
   input  wire logic [COORD_BITS-1:0] cur_x,
   input  wire logic [COORD_BITS-1:0] cur_y,
   output logic                       due,
   output logic                       any_dir,
   output logic [TIME_BITS-1:0]       hold_next,
   output logic [COORD_BITS-1:0]      nx,
   output logic [COORD_BITS-1:0]      ny,
   output logic                       moved
);
   import gtp_pkg::*;

   localparam int SW = ((COORD_BITS > 8) ? COORD_BITS : 8) + 2;
   localparam logic [BOUND_BITS-1:0] BOUND_MASK =
      BOUND_BITS'((64'd1 << COORD_BITS) - 64'd1);
   localparam logic [TIME_BITS-1:0] PERIOD = TIME_BITS'(MOVE_PERIOD_US);

   logic [TIME_BITS-1:0] since_move;
   logic [TIME_BITS-1:0] hold_eff;
   logic [TIME_BITS-1:0] since_hold;
   logic [TIME_BITS-1:0] accel;
   logic                 fast;
   logic [7:0]           step;
   logic [SW-1:0]        mx;
   logic [SW-1:0]        my;

   function automatic logic [COORD_BITS-1:0] clamp_axis(
      input logic [COORD_BITS-1:0] pos,
      input logic                  inc,
      input logic                  dec,
      input logic [7:0]            stp,
      input logic [SW-1:0]         hi
   );
      logic signed [SW-1:0] sum;
      logic [COORD_BITS-1:0] res;
      sum = $signed(SW'(pos));
      if (inc && !dec) begin
         sum = sum + $signed(SW'(stp));
      end else if (dec && !inc) begin
         sum = sum - $signed(SW'(stp));
      end
      if (sum < 0) begin
         res = '0;
      end else if (sum > $signed(hi)) begin
         res = COORD_BITS'(hi);
      end else begin
         res = COORD_BITS'(sum);
      end
      return res;
   endfunction

   assign since_move = now - last_move;
   assign due        = (now >= last_move) && (since_move >= PERIOD);

   // a hold start of zero means no hold yet: start it now
   assign hold_eff   = (hold_start == '0) ? now : hold_start;
   assign since_hold = now - hold_eff;
   assign accel      = TIME_BITS'(cfg.accel_time_us);
   assign fast       = (now >= hold_eff) && (since_hold > accel);
   assign step       = fast ? cfg.fast_step : cfg.slow_step;
   assign hold_next  = hold_eff;

   assign mx = SW'((ovl ? cfg.overlay_max_x : cfg.game_max_x) & BOUND_MASK);
   assign my = SW'((ovl ? cfg.overlay_max_y : cfg.game_max_y) & BOUND_MASK);

   // bit 0 up, 1 down, 2 left, 3 right
   assign any_dir = (dir[3] ^ dir[2]) | (dir[1] ^ dir[0]);
   assign nx      = clamp_axis(cur_x, dir[3], dir[2], step, mx);
   assign ny      = clamp_axis(cur_y, dir[1], dir[0], step, my);
   assign moved   = (nx != cur_x) || (ny != cur_y);

endmodule
`default_nettype wire

// ----- sv/gamepad_to_pointer_events_unit.sv -----
// Top level: input register, event/move logic, result register and CSR block.
// Flow: a req word is held in the input register, then in the result register, where
//   rsp_valid rises; one word per cycle sustained while rsp_ready stays high, set by the single
//   pass through the button scan and the pointer step between the registers.
// Reset (synchronous, active high): registers return to their defaults, button
//   states, move time, hold start and cursor clear, and both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module gamepad_to_pointer_events_unit #(
   parameter int TIME_BITS  = gtp_pkg::TIME_BITS_DEF,
   parameter int COORD_BITS = gtp_pkg::COORD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [TIME_BITS-1:0]                req_now_us,
   input  wire logic [9:0]                          req_pressed,
   input  wire logic                                req_overlay_visible,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [3:0]                               rsp_event_kind,
   output logic [2:0]                               rsp_key_code,
   output logic [COORD_BITS-1:0]                    rsp_pointer_x,
   output logic [COORD_BITS-1:0]                    rsp_pointer_y,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gtp_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  wire logic [gtp_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic      [gtp_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                     pready
);
   import gtp_pkg::*;

   cfg_type cfg;

   // input stage
   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [TIME_BITS-1:0]  in_now_ff;
   logic [9:0]            in_pressed_ff;
   logic                  in_ovl_ff;

   // result stage
   logic                  out_valid_ff;
   logic                  out_valid_in;
   event_kind_type        out_kind_ff;
   event_kind_type        out_kind_in;
   logic [2:0]            out_key_ff;
   logic [2:0]            out_key_in;
   logic [COORD_BITS-1:0] out_x_ff;
   logic [COORD_BITS-1:0] out_x_in;
   logic [COORD_BITS-1:0] out_y_ff;
   logic [COORD_BITS-1:0] out_y_in;

   // block state
   logic [NUM_ACTIONS-1:0] seen_ff;
   logic [NUM_ACTIONS-1:0] seen_in;
   logic [TIME_BITS-1:0]   last_move_ff;
   logic [TIME_BITS-1:0]   last_move_in;
   logic [TIME_BITS-1:0]   hold_ff;
   logic [TIME_BITS-1:0]   hold_in;
   logic [COORD_BITS-1:0]  cur_x_ff;
   logic [COORD_BITS-1:0]  cur_x_in;
   logic [COORD_BITS-1:0]  cur_y_ff;
   logic [COORD_BITS-1:0]  cur_y_in;

   logic                   advance;
   logic                   take;
   button_event_type       bev;
   logic [NUM_ACTIONS-1:0] seen_next;
   logic                   due;
   logic                   any_dir;
   logic [TIME_BITS-1:0]   hold_next;
   logic [COORD_BITS-1:0]  nx;
   logic [COORD_BITS-1:0]  ny;
   logic                   moved;

   gtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gtp_buttons u_buttons (
      .acts       (in_pressed_ff[9:4]),
      .seen       (seen_ff),
      .action_map (cfg.action_map),
      .ev         (bev),
      .seen_next  (seen_next)
   );

   gtp_pointer #(
      .TIME_BITS  (TIME_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_pointer (
      .now        (in_now_ff),
      .dir        (in_pressed_ff[3:0]),
      .ovl        (in_ovl_ff),
      .cfg        (cfg),
      .last_move  (last_move_ff),
      .hold_start (hold_ff),
      .cur_x      (cur_x_ff),
      .cur_y      (cur_y_ff),
      .due        (due),
      .any_dir    (any_dir),
      .hold_next  (hold_next),
      .nx         (nx),
      .ny         (ny),
      .moved      (moved)
   );

   // advance the held word when the result register is free or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   assign rsp_valid      = out_valid_ff;
   assign rsp_event_kind = out_kind_ff;
   assign rsp_key_code   = out_key_ff;
   assign rsp_pointer_x  = out_x_ff;
   assign rsp_pointer_y  = out_y_ff;

   always_comb begin
      in_valid_in  = take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

      out_kind_in  = EV_NONE;
      out_key_in   = KEY_ESC;
      out_x_in     = '0;
      out_y_in     = '0;
      seen_in      = seen_ff;
      last_move_in = last_move_ff;
      hold_in      = hold_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;

      if (advance) begin
         seen_in = seen_next;
         if (bev.hit) begin
            out_kind_in = bev.kind;
            out_key_in  = bev.key;
            if (bev.with_pos) begin
               out_x_in = cur_x_ff;
               out_y_in = cur_y_ff;
            end
         end else if (due) begin
            last_move_in = in_now_ff;
            if (!any_dir) begin
               hold_in = '0;
            end else begin
               hold_in = hold_next;
               if (moved) begin
                  cur_x_in    = nx;
                  cur_y_in    = ny;
                  out_kind_in = EV_MOVE;
                  out_x_in    = nx;
                  out_y_in    = ny;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seen_ff      <= '0;
         last_move_ff <= '0;
         hold_ff      <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seen_ff      <= seen_in;
         last_move_ff <= last_move_in;
         hold_ff      <= hold_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_now_ff     <= req_now_us;
         in_pressed_ff <= req_pressed;
         in_ovl_ff     <= req_overlay_visible;
      end
      if (advance) begin
         out_kind_ff <= out_kind_in;
         out_key_ff  <= out_key_in;
         out_x_ff    <= out_x_in;
         out_y_ff    <= out_y_in;
      end
   end

   a_advance_fills_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("held word did not reach the result register");

   a_position_only_with_pointer_events: assert property (@(posedge clock)
      disable iff (reset)
      (rsp_valid && !(rsp_event_kind == EV_LDOWN || rsp_event_kind == EV_LUP ||
                      rsp_event_kind == EV_RDOWN || rsp_event_kind == EV_RUP ||
                      rsp_event_kind == EV_MOVE))
      |-> (rsp_pointer_x == '0 && rsp_pointer_y == '0))
      else $error("position carried on an event without a pointer");

   a_key_only_with_key_events: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_event_kind == EV_KDOWN || rsp_event_kind == EV_KUP))
      |-> (rsp_key_code == KEY_ESC))
      else $error("key code set on a non-key event");

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Testbench for the gamepad-to-pointer event unit: stimulus, predictor and result checks.
`timescale 1ns / 1ps
module tb_top;
   import gtp_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;

   localparam logic [9:0] BTN_UP     = 10'h001;
   localparam logic [9:0] BTN_DOWN   = 10'h002;
   localparam logic [9:0] BTN_LEFT   = 10'h004;
   localparam logic [9:0] BTN_RIGHT  = 10'h008;
   localparam logic [9:0] BTN_A      = 10'h010;
   localparam logic [9:0] BTN_B      = 10'h020;
   localparam logic [9:0] BTN_C      = 10'h040;
   localparam logic [9:0] BTN_D      = 10'h080;
   localparam logic [9:0] BTN_START  = 10'h100;
   localparam logic [9:0] BTN_SELECT = 10'h200;

   typedef struct {
      event_kind_type kind;
      logic [2:0]     key;
      logic [11:0]    x;
      logic [11:0]    y;
   } pointer_event_rec;

   class pointer_event_tracker;
      logic [23:0] action_map;
      logic [7:0]  slow_step;
      logic [7:0]  fast_step;
      logic [31:0] accel_time;
      logic [11:0] game_mx, game_my, ovl_mx, ovl_my;

      logic [5:0]  buttons_seen;
      logic [47:0] last_move, hold_start;
      logic [11:0] cur_x, cur_y;

      pointer_event_rec expected_events[$];
      int errors;
      int polls_noted;
      int kind_count[9];

      function new();
         action_map   = RST_ACTION_MAP;
         slow_step    = RST_SLOW_STEP;
         fast_step    = RST_FAST_STEP;
         accel_time   = RST_ACCEL_TIME;
         game_mx      = RST_GAME_MAX_X;
         game_my      = RST_GAME_MAX_Y;
         ovl_mx       = RST_OVERLAY_MAX_X;
         ovl_my       = RST_OVERLAY_MAX_Y;
         buttons_seen = '0;
         last_move    = '0;
         hold_start   = '0;
         cur_x        = '0;
         cur_y        = '0;
         errors       = 0;
         polls_noted  = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void set_register(logic [REG_IDX_BITS-1:0] idx, logic [31:0] value);
         case (idx)
            REG_ACTION_MAP:    action_map = value[23:0];
            REG_SLOW_STEP:     slow_step  = value[7:0];
            REG_FAST_STEP:     fast_step  = value[7:0];
            REG_ACCEL_TIME:    accel_time = value;
            REG_GAME_MAX_X:    game_mx    = value[11:0];
            REG_GAME_MAX_Y:    game_my    = value[11:0];
            REG_OVERLAY_MAX_X: ovl_mx     = value[11:0];
            REG_OVERLAY_MAX_Y: ovl_my     = value[11:0];
            default: ;
         endcase
      endfunction

      function int pending_count();
         return expected_events.size();
      endfunction

      function void note_mismatch(string msg);
         errors++;
         if (errors <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
      endfunction

      // Work out the one result that a poll produces and advance the state.
      function void note_poll(logic [47:0] now, logic [9:0] pressed, logic ovl);
         pointer_event_rec ev;
         logic [5:0] acts;
         logic       chord, dn, done, with_pos;
         logic [3:0] code;
         int dx, dy, step, mx, my, cx, cy, nx, ny;
         ev.kind  = EV_NONE;
         ev.key   = '0;
         ev.x     = '0;
         ev.y     = '0;
         with_pos = 1'b0;
         done     = 1'b0;
         acts     = pressed[9:4];
         chord    = acts[4] & acts[5];
         for (int i = 0; i < NUM_ACTIONS; i++) begin
            if (!done && acts[i] != buttons_seen[i]) begin
               dn = acts[i];
               buttons_seen[i] = dn;
               code = action_map[4*i +: 4];
               if (!(i >= FIRST_CHORD && chord)) begin
                  case (code)
                     ACT_NONE: ;
                     ACT_LEFT: begin
                        ev.kind  = dn ? EV_LDOWN : EV_LUP;
                        with_pos = 1'b1;
                        done     = 1'b1;
                     end
                     ACT_RIGHT: begin
                        ev.kind  = dn ? EV_RDOWN : EV_RUP;
                        with_pos = 1'b1;
                        done     = 1'b1;
                     end
                     ACT_VKBD: begin
                        // release of the keyboard button is silent; keep scanning
                        if (dn) begin
                           ev.kind = EV_VKBD;
                           done    = 1'b1;
                        end
                     end
                     default: begin
                        ev.kind = dn ? EV_KDOWN : EV_KUP;
                        case (code)
                           ACT_ESC:   ev.key = KEY_ESC;
                           ACT_SPACE: ev.key = KEY_SPACE;
                           ACT_F5:    ev.key = KEY_F5;
                           ACT_F7:    ev.key = KEY_F7;
                           default:   ev.key = KEY_RETURN;
                        endcase
                        done = 1'b1;
                     end
                  endcase
               end
            end
         end

         if (!done && now >= last_move && (now - last_move) >= MOVE_PERIOD_US) begin
            last_move = now;
            dx = (pressed[3] ? 1 : 0) - (pressed[2] ? 1 : 0);
            dy = (pressed[1] ? 1 : 0) - (pressed[0] ? 1 : 0);
            if (dx == 0 && dy == 0) begin
               hold_start = '0;
            end else begin
               if (hold_start == '0) hold_start = now;
               if (now >= hold_start && (now - hold_start) > 48'(accel_time))
                  step = fast_step;
               else
                  step = slow_step;
               mx = ovl ? ovl_mx : game_mx;
               my = ovl ? ovl_my : game_my;
               cx = cur_x;
               cy = cur_y;
               nx = cx + dx * step;
               ny = cy + dy * step;
               if (nx > mx) nx = mx;
               if (nx < 0) nx = 0;
               if (ny > my) ny = my;
               if (ny < 0) ny = 0;
               if (nx != cx || ny != cy) begin
                  cur_x    = nx[11:0];
                  cur_y    = ny[11:0];
                  ev.kind  = EV_MOVE;
                  with_pos = 1'b1;
               end
            end
         end

         if (with_pos) begin
            ev.x = cur_x;
            ev.y = cur_y;
         end
         expected_events.push_back(ev);
         polls_noted++;
      endfunction

      function void check_event(logic [3:0] kind, logic [2:0] key, logic [11:0] x,
                                logic [11:0] y);
         pointer_event_rec exp_ev;
         if (!$isunknown(kind) && kind <= EV_MOVE) kind_count[kind]++;
         if (expected_events.size() == 0) begin
            note_mismatch($sformatf("result kind %0d with nothing outstanding", kind));
            return;
         end
         exp_ev = expected_events.pop_front();
         if (kind !== exp_ev.kind || key !== exp_ev.key || x !== exp_ev.x || y !== exp_ev.y)
            note_mismatch($sformatf(
               "kind %0d/%0d key %0d/%0d x %0d/%0d y %0d/%0d (expected/actual)",
               exp_ev.kind, kind, exp_ev.key, key, exp_ev.x, x, exp_ev.y, y));
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [47:0] req_now_us;
   logic [9:0]  req_pressed;
   logic        req_overlay_visible;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [3:0]  rsp_event_kind;
   logic [2:0]  rsp_key_code;
   logic [11:0] rsp_pointer_x;
   logic [11:0] rsp_pointer_y;
   logic        psel, penable, pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic        pready;

   gamepad_to_pointer_events_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_now_us          (req_now_us),
      .req_pressed         (req_pressed),
      .req_overlay_visible (req_overlay_visible),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_key_code        (rsp_key_code),
      .rsp_pointer_x       (rsp_pointer_x),
      .rsp_pointer_y       (rsp_pointer_y),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   pointer_event_tracker tracker = new();

   logic [47:0] now_clock   = 48'd0;
   logic [3:0]  dpad        = 4'b0000;
   logic [5:0]  action_bits = 6'b0;
   logic        overlay     = 1'b0;
   int          dpad_run    = 0;
   int          settings_used = 1;
   int          idle_cycles = 0;
   int unsigned stall_tick  = 0;
   logic [15:0] stall_mask  = 16'hFFFF;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Result side: check every accepted word, stall on a rotating mask.
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
         tracker.check_event(rsp_event_kind, rsp_key_code, rsp_pointer_x, rsp_pointer_y);
      stall_tick <= stall_tick + 1;
      if (stall_tick[7:0] == 8'd0)
         stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      rsp_ready <= stall_mask[stall_tick[3:0]];
   end

   always @(posedge clock) begin
      if ((req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1) || (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d cycles without progress", idle_cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Call right after a rising edge; returns at the edge that accepts the word.
   task automatic send_poll(input logic [47:0] t, input logic [9:0] p, input logic o);
      req_valid           <= 1'b1;
      req_now_us          <= t;
      req_pressed         <= p;
      req_overlay_visible <= o;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_poll(t, p, o);
   endtask

   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      tracker.set_register(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [23:0] amap, input logic [7:0] slow,
                                 input logic [7:0] fast, input logic [31:0] accel,
                                 input logic [11:0] gmx, input logic [11:0] gmy,
                                 input logic [11:0] omx, input logic [11:0] omy);
      // hold until the pipe is empty before touching registers
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write(REG_ACTION_MAP, {8'd0, amap});
      csr_write(REG_SLOW_STEP, {24'd0, slow});
      csr_write(REG_FAST_STEP, {24'd0, fast});
      csr_write(REG_ACCEL_TIME, accel);
      csr_write(REG_GAME_MAX_X, {20'd0, gmx});
      csr_write(REG_GAME_MAX_Y, {20'd0, gmy});
      csr_write(REG_OVERLAY_MAX_X, {20'd0, omx});
      csr_write(REG_OVERLAY_MAX_Y, {20'd0, omy});
      settings_used++;
   endtask

   task automatic run_random_polls(input int count);
      int burst_left, r;
      logic [47:0] t;
      burst_left = $urandom_range(1, 40);
      for (int n = 0; n < count; n++) begin
         if (dpad_run == 0) begin
            r = $urandom_range(0, 9);
            case (r)
               0, 1:       dpad = 4'b0000;
               2, 3, 4, 5: dpad = 4'b0001 << $urandom_range(0, 3);
               6, 7:       dpad = {($urandom_range(0, 1) ? 2'b10 : 2'b01),
                                   ($urandom_range(0, 1) ? 2'b10 : 2'b01)};
               default:    dpad = 4'($urandom);
            endcase
            dpad_run = $urandom_range(1, 60);
         end
         dpad_run--;

         r = $urandom_range(0, 15);
         if (r < 4) action_bits[$urandom_range(0, 5)] ^= 1'b1;
         else if (r == 4) action_bits = 6'($urandom);
         else if (r == 5) action_bits[5:4] = 2'b11;
         if ($urandom_range(0, 19) == 0) overlay = ~overlay;

         // mostly move-rate cadence, some fast and period-edge polls, rare long jumps and stale stamps
         r = $urandom_range(0, 99);
         if (r < 60) now_clock += 48'(16667 + $urandom_range(0, 3000));
         else if (r < 80) now_clock += 48'($urandom_range(0, 16666));
         else if (r < 90) now_clock += ($urandom_range(0, 1) ? 48'd16666 : 48'd16667);
         else if (r < 95) now_clock += 48'($urandom) << $urandom_range(0, 6);
         t = now_clock;
         if (r >= 95) t = now_clock - 48'($urandom_range(1, 40000));

         send_poll(t, {action_bits, dpad}, overlay);
         burst_left--;
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            burst_left = $urandom_range(1, 40);
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_now_us          <= '0;
      req_pressed         <= '0;
      req_overlay_visible <= 1'b0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed polls at the reset register values
      send_poll(48'd0,    10'd0, 1'b0);
      send_poll(48'd100,  BTN_A, 1'b0);
      send_poll(48'd200,  10'd0, 1'b0);
      send_poll(48'd300,  BTN_B, 1'b0);
      send_poll(48'd400,  10'd0, 1'b0);
      send_poll(48'd500,  BTN_C, 1'b0);
      send_poll(48'd600,  BTN_C | BTN_D, 1'b0);
      send_poll(48'd700,  BTN_C | BTN_D | BTN_START, 1'b0);
      send_poll(48'd800,  BTN_C | BTN_D | BTN_START | BTN_SELECT, 1'b0);
      send_poll(48'd900,  BTN_C | BTN_D | BTN_START, 1'b0);
      send_poll(48'd1000, BTN_C | BTN_D | BTN_SELECT, 1'b0);
      send_poll(48'd1100, 10'd0, 1'b0);
      send_poll(48'd1200, 10'd0, 1'b0);
      send_poll(48'd1300, 10'd0, 1'b0);
      send_poll(48'd20000,  BTN_RIGHT, 1'b0);
      send_poll(48'd36666,  BTN_RIGHT, 1'b0);
      send_poll(48'd36667,  BTN_RIGHT, 1'b0);
      send_poll(48'd600000, BTN_RIGHT, 1'b0);
      send_poll(48'd620000, BTN_LEFT | BTN_RIGHT, 1'b0);
      send_poll(48'd640000, BTN_UP, 1'b0);
      send_poll(48'd660000, BTN_DOWN, 1'b1);
      send_poll(48'd500,    BTN_DOWN, 1'b1);
      send_poll(48'hFFFF_FFFF_FFFF, 10'h3FF, 1'b1);
      send_poll(48'hFFFF_FFFF_FFFF, 10'd0, 1'b0);
      req_valid <= 1'b0;
      now_clock = 48'd700000;

      apply_settings(24'h819043, 8'd0, 8'd255, 32'd0, 12'd4095, 12'd4095, 12'd0, 12'd0);
      run_random_polls(160);
      apply_settings(24'hFFFFFF, 8'd255, 8'd0, 32'hFFFF_FFFF, 12'd0, 12'd0,
                     12'd4095, 12'd4095);
      run_random_polls(160);
      apply_settings(24'h000000, 8'd3, 8'd17, 32'd60000, 12'd639, 12'd479, 12'd319, 12'd239);
      run_random_polls(160);
      repeat (3) begin
         apply_settings(24'($urandom), 8'($urandom), 8'($urandom),
                        32'($urandom_range(0, 300000)), 12'($urandom), 12'($urandom),
                        12'($urandom), 12'($urandom));
         run_random_polls(160);
      end
      apply_settings(RST_ACTION_MAP, RST_SLOW_STEP, RST_FAST_STEP, RST_ACCEL_TIME,
                     RST_GAME_MAX_X, RST_GAME_MAX_Y, RST_OVERLAY_MAX_X, RST_OVERLAY_MAX_Y);
      run_random_polls(160);

      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("ran %0d polls across %0d register settings", tracker.polls_noted,
               settings_used);
      $display("seen: %0d none, %0d clicks, %0d keys, %0d vkbd, %0d moves",
               tracker.kind_count[EV_NONE],
               tracker.kind_count[EV_LDOWN] + tracker.kind_count[EV_LUP] +
               tracker.kind_count[EV_RDOWN] + tracker.kind_count[EV_RUP],
               tracker.kind_count[EV_KDOWN] + tracker.kind_count[EV_KUP],
               tracker.kind_count[EV_VKBD], tracker.kind_count[EV_MOVE]);
      if (tracker.errors == 0 && tracker.pending_count() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
